/* rtl/core/tca_pkg.sv */
// Shared types and codes for the two-additive Choquet aggregator.
`timescale 1ns / 1ps
package tca_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_VALUE = 2'd2;

    localparam logic [1:0] STATUS_OK             = 2'd0;
    localparam logic [1:0] STATUS_NOT_NORMALIZED = 2'd1;
    localparam logic [1:0] STATUS_BAD_COUNT      = 2'd2;
    localparam logic [1:0] STATUS_BAD_INDEX      = 2'd3;

    localparam int ONE_Q14 = 16384;
    localparam int SCORE_W = 48;
    localparam logic [4:0] NUM_CRIT_RESET = 5'd16;

    typedef struct packed {
        logic clear;
        logic step;
        logic diag;
    } tca_dp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic sum_ok;
    } tca_dp_stat_t;

endpackage

/* rtl/core/tca_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tca_datapath.sv */
// Pair-term multiply, score accumulator and normalization sum for the table pass.
`timescale 1ns / 1ps
module tca_datapath import tca_pkg::*; #(
    parameter int DEPTH = 136
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tca_dp_ctrl_t              ctrl,
    input  logic signed [15:0]        p_data,
    input  logic        [15:0]        x_data,
    output tca_dp_stat_t              stat,
    output logic signed [SCORE_W-1:0] acc
);

    localparam int SUM_W = 16 + $clog2(DEPTH + 1);

    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_diag_reg;
    logic                      s2_valid_reg, s2_valid_next;
    logic        [15:0]        xi_reg, xi_next;
    logic signed [33:0]        prod_reg, prod_next;
    logic signed [SCORE_W-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;

    logic signed [16:0] diff;
    logic        [15:0] abs_diff;
    logic signed [17:0] mult_op;

    always_comb
    begin
        s1_valid_next = ctrl.step;
        s2_valid_next = s1_valid_reg;
        xi_next       = xi_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        sum_next      = sum_reg;

        diff     = $signed({1'b0, xi_reg}) - $signed({1'b0, x_data});
        abs_diff = diff[16] ? 16'(-diff) : 16'(diff);
        if (s1_diag_reg)
        begin
            mult_op = $signed({1'b0, x_data, 1'b0});
        end
        else
        begin
            mult_op = -$signed({2'b00, abs_diff});
        end

        if (s1_valid_reg)
        begin
            if (s1_diag_reg)
            begin
                xi_next = x_data;
            end
            prod_next = 34'(p_data) * 34'(mult_op);
            sum_next  = sum_reg + SUM_W'(p_data);
        end
        if (s2_valid_reg)
        begin
            acc_next = acc_reg + {{(SCORE_W - 34){prod_reg[33]}}, prod_reg};
        end
        if (ctrl.clear)
        begin
            acc_next = '0;
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diag_reg <= ctrl.diag;
        xi_reg      <= xi_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        sum_reg     <= sum_next;
    end

    assign stat.busy   = s1_valid_reg | s2_valid_reg;
    assign stat.sum_ok = (sum_reg == SUM_W'(ONE_Q14));
    assign acc         = acc_reg;

endmodule

/* rtl/core/two_additive_choquet_aggregator.sv */
// Two-additive Choquet aggregator: parameter table, value buffer and sequencer.
// Table write: no result. Table read: the entry is registered in ST_READ, then
// loaded out in ST_EMIT. A bad index emits only a status. Last value: one pass
// over the n*(n+1)/2 upper-triangle entries, one per cycle through the table RAM
// read port, then ST_DRAIN and ST_EMIT. One item is in work at a time; the input
// stalls until its result is loaded. Reset: a clearing pass zeroes the table.
`timescale 1ns / 1ps
module two_additive_choquet_aggregator import tca_pkg::*; #(
    parameter int MAX_CRITERIA = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                func,
    input  logic [3:0]                row,
    input  logic [3:0]                col,
    input  logic signed [15:0]        weight,
    input  logic [15:0]               crit_value,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [SCORE_W-1:0] score,
    output logic signed [15:0]        read_weight,
    output logic [1:0]                status,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [4:0]                cfg_data
);

    localparam int DEPTH = MAX_CRITERIA * (MAX_CRITERIA + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = $clog2(MAX_CRITERIA);
    localparam int NW    = $clog2(MAX_CRITERIA + 1);
    localparam int XW    = (NW > 4) ? NW : 4;
    localparam int PW    = AW + 6;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_PASS  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [4:0]    num_crit_reg, num_crit_next;
    logic [NW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          verified_reg, verified_next;
    logic          count_bad_reg, count_bad_next;
    logic [VW-1:0] i_reg, i_next;
    logic [VW-1:0] j_reg, j_next;
    logic [AW-1:0] t_reg, t_next;
    logic          out_valid_reg, out_valid_next;

    logic signed [SCORE_W-1:0] pend_score_reg, pend_score_next;
    logic signed [15:0]        pend_rw_reg, pend_rw_next;
    logic [1:0]                pend_status_reg, pend_status_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic signed [15:0]        read_weight_reg, read_weight_next;
    logic [1:0]                status_reg, status_next;

    logic [NW-1:0] n_eff;
    logic [VW-1:0] n_last;
    logic [AW-1:0] row_skip;
    logic          in_acc;
    logic          bad_index;
    logic [3:0]    tri_lo, tri_hi;
    logic [PW-1:0] tri_prod;
    logic [AW-1:0] tri_idx;
    logic          stored;
    logic [NW-1:0] count_after;
    logic          count_bad;
    logic          out_free;

    logic          tbl_we, tbl_re;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    logic [15:0]   tbl_wdata, tbl_rdata;
    logic          val_we, val_re;
    logic [15:0]   val_rdata;

    tca_dp_ctrl_t              dp_ctrl;
    tca_dp_stat_t              dp_stat;
    logic signed [SCORE_W-1:0] dp_acc;

    tca_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    tca_ram #(
        .WIDTH (16),
        .DEPTH (MAX_CRITERIA)
    ) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (count_reg[VW-1:0]),
        .wdata (crit_value),
        .re    (val_re),
        .raddr (j_reg),
        .rdata (val_rdata)
    );

    tca_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (dp_ctrl),
        .p_data ($signed(tbl_rdata)),
        .x_data (val_rdata),
        .stat   (dp_stat),
        .acc    (dp_acc)
    );

    always_comb
    begin
        if (num_crit_reg == 5'd0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(num_crit_reg) > MAX_CRITERIA)
        begin
            n_eff = NW'(MAX_CRITERIA);
        end
        else
        begin
            n_eff = NW'(num_crit_reg);
        end
        n_last   = VW'(n_eff - NW'(1));
        row_skip = AW'(MAX_CRITERIA) - AW'(n_eff);

        tri_lo   = (row < col) ? row : col;
        tri_hi   = (row < col) ? col : row;
        tri_prod = PW'(tri_lo) * (PW'(2 * MAX_CRITERIA + 1) - PW'(tri_lo));
        tri_idx  = AW'(tri_prod >> 1) + AW'(tri_hi - tri_lo);

        bad_index = (XW'(row) >= XW'(n_eff)) || (XW'(col) >= XW'(n_eff));
        in_acc    = in_valid && !in_stall;

        stored      = int'(count_reg) < MAX_CRITERIA;
        count_after = count_reg + NW'(stored);
        count_bad   = (ovf_reg || !stored) || (count_after != n_eff);
        out_free    = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        num_crit_next    = num_crit_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        verified_next    = verified_reg;
        count_bad_next   = count_bad_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        t_next           = t_reg;
        out_valid_next   = out_valid_reg;
        pend_score_next  = pend_score_reg;
        pend_rw_next     = pend_rw_reg;
        pend_status_next = pend_status_reg;
        score_next       = score_reg;
        read_weight_next = read_weight_reg;
        status_next      = status_reg;

        tbl_we    = 1'b0;
        tbl_waddr = tri_idx;
        tbl_wdata = weight;
        tbl_re    = 1'b0;
        tbl_raddr = tri_idx;
        val_we    = 1'b0;
        val_re    = 1'b0;

        dp_ctrl.clear = 1'b0;
        dp_ctrl.step  = 1'b0;
        dp_ctrl.diag  = (i_reg == j_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                tbl_we        = 1'b1;
                tbl_waddr     = clr_addr_reg;
                tbl_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    pend_score_next  = '0;
                    pend_rw_next     = '0;
                    pend_status_next = STATUS_OK;
                    case (func)
                        FUNC_WRITE:
                        begin
                            if (bad_index)
                            begin
                                pend_status_next = STATUS_BAD_INDEX;
                                state_next       = ST_EMIT;
                            end
                            else
                            begin
                                tbl_we        = 1'b1;
                                verified_next = 1'b0;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (bad_index)
                            begin
                                pend_status_next = STATUS_BAD_INDEX;
                                state_next       = ST_EMIT;
                            end
                            else
                            begin
                                tbl_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        FUNC_VALUE:
                        begin
                            if (stored)
                            begin
                                val_we     = 1'b1;
                                count_next = count_after;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            if (last)
                            begin
                                count_next     = '0;
                                ovf_next       = 1'b0;
                                count_bad_next = count_bad;
                                if (verified_reg && count_bad)
                                begin
                                    pend_status_next = STATUS_BAD_COUNT;
                                    state_next       = ST_EMIT;
                                end
                                else
                                begin
                                    dp_ctrl.clear = 1'b1;
                                    i_next        = '0;
                                    j_next        = '0;
                                    t_next        = '0;
                                    state_next    = ST_PASS;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                pend_rw_next = $signed(tbl_rdata);
                state_next   = ST_EMIT;
            end
            ST_PASS:
            begin
                tbl_re       = 1'b1;
                tbl_raddr    = t_reg;
                val_re       = 1'b1;
                dp_ctrl.step = 1'b1;
                if (j_reg == n_last)
                begin
                    if (i_reg == n_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + VW'(1);
                        j_next = i_reg + VW'(1);
                        t_next = t_reg + AW'(1) + row_skip;
                    end
                end
                else
                begin
                    j_next = j_reg + VW'(1);
                    t_next = t_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!dp_stat.busy)
                begin
                    state_next = ST_EMIT;
                    if (!verified_reg && !dp_stat.sum_ok)
                    begin
                        pend_status_next = STATUS_NOT_NORMALIZED;
                    end
                    else
                    begin
                        verified_next = 1'b1;
                        if (count_bad_reg)
                        begin
                            pend_status_next = STATUS_BAD_COUNT;
                        end
                        else
                        begin
                            pend_score_next = dp_acc;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    score_next       = pend_score_reg;
                    read_weight_next = pend_rw_reg;
                    status_next      = pend_status_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            num_crit_next = cfg_data;
            verified_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            num_crit_reg  <= NUM_CRIT_RESET;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            verified_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            num_crit_reg  <= num_crit_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            verified_reg  <= verified_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_bad_reg   <= count_bad_next;
        i_reg           <= i_next;
        j_reg           <= j_next;
        t_reg           <= t_next;
        pend_score_reg  <= pend_score_next;
        pend_rw_reg     <= pend_rw_next;
        pend_status_reg <= pend_status_next;
        score_reg       <= score_next;
        read_weight_reg <= read_weight_next;
        status_reg      <= status_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign score       = score_reg;
    assign read_weight = read_weight_reg;
    assign status      = status_reg;

    a_score_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STATUS_OK) |-> (score_reg == '0))
        else $error("score nonzero with failing status");

    a_verify_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verified_reg) |-> ($past(state_reg) == ST_DRAIN))
        else $error("verified mark set outside the table pass");

    a_idle_dp_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !dp_stat.busy)
        else $error("datapath busy while idle");

    a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS) |-> (int'(t_reg) < DEPTH) && (j_reg >= i_reg))
        else $error("table pass address out of range");

endmodule
